[sv/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// An implication checked in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

[sv/tmf_pkg.sv]
package tmf_pkg;

  // Width of one ADC word and of the filtered value.
  localparam int SAMPLE_BITS = 12;

  localparam int DEFAULT_WINDOW = 30;
  localparam int DEFAULT_TRIM   = 2;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_THRESHOLD = 1'd1;

  localparam logic [SAMPLE_BITS-1:0] THRESHOLD_RESET = '1;
  localparam logic [SAMPLE_BITS-1:0] SMALLEST_RESET  = '1;

endpackage

[sv/tmf_divide.sv]
// Constant division of the block sum by the window or by the trimmed
// window, done as a multiply by a rounded-up reciprocal and a shift.
module tmf_divide import tmf_pkg::*; #(
  parameter int WINDOW = DEFAULT_WINDOW,
  parameter int TRIM   = DEFAULT_TRIM,
  localparam int TOT_W = SAMPLE_BITS + $clog2(WINDOW)
) (
  input  logic [TOT_W-1:0]       numer_i,
  input  logic                   trim_i,
  output logic [SAMPLE_BITS-1:0] quot_o
);

  // One shift serves both divisors: it is wide enough for the larger one.
  localparam int SHIFT    = TOT_W + $clog2(WINDOW);
  localparam int M_W      = SHIFT + 1;
  localparam int PROD_W   = TOT_W + M_W;
  localparam int DIV_TRIM = WINDOW - 2 * TRIM;

  localparam logic [M_W-1:0] RECIP_FULL =
    M_W'(((longint'(1) << SHIFT) + longint'(WINDOW) - 1) / longint'(WINDOW));
  localparam logic [M_W-1:0] RECIP_TRIM =
    M_W'(((longint'(1) << SHIFT) + longint'(DIV_TRIM) - 1) / longint'(DIV_TRIM));

  logic [M_W-1:0]    recip;
  logic [PROD_W-1:0] prod;

  assign recip  = trim_i ? RECIP_TRIM : RECIP_FULL;
  assign prod   = PROD_W'(numer_i) * PROD_W'(recip);
  assign quot_o = prod[SHIFT +: SAMPLE_BITS];

endmodule

[sv/block_trimmed_mean_filter.sv]
// Block mean / trimmed mean filter for 12-bit ADC words. Words are grouped in
// blocks of WINDOW; the word that closes a block loads the held value with the
// truncated block mean (filter_mode 0) or with the truncated mean of the block
// after the TRIM smallest and TRIM largest words are dropped (filter_mode 1).
// Every input word gives exactly one output word carrying the held value as it
// stands after that word (zero until the first block closes), an over_limit
// flag (held value above limit_threshold) and a block_end mark. The block
// takes one word per clock cycle while its results are read, and each word
// passes through an input register, an accumulate stage that keeps the
// running sum and the two smallest and two largest words, a trim stage that
// forms the numerator, and an output register loaded through a reciprocal
// multiplier. Every stage stalls only when the one after it is full, so
// bubbles are absorbed and a new word is taken while a finished result waits
// to be read. Write the configuration only while no word is in flight.
module block_trimmed_mean_filter import tmf_pkg::*; #(
  parameter int WINDOW = DEFAULT_WINDOW,
  parameter int TRIM   = DEFAULT_TRIM
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Sample channel.
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  // Result channel.
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [SAMPLE_BITS-1:0] filtered_o,
  output logic                   over_limit_o,
  output logic                   block_end_o,
  // Configuration writes.
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int TOT_W = SAMPLE_BITS + $clog2(WINDOW);
  localparam int CNT_W = $clog2(WINDOW);
  localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(WINDOW - 1);

  // Configuration registers.
  logic                   mode_q;
  logic [SAMPLE_BITS-1:0] thresh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      thresh_q <= THRESHOLD_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FILTER_MODE:     mode_q   <= cfg_data_i[0];
        CFG_LIMIT_THRESHOLD: thresh_q <= cfg_data_i[SAMPLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Stage valids and the ready chain. A stage can load when it is empty or
  // when its word moves on in the same cycle.
  logic s1_v_q, s2_v_q, s3_v_q, out_v_q;
  logic s1_rdy, s2_rdy, s3_rdy, out_rdy;

  assign out_rdy    = !out_v_q || out_ready_i;
  assign s3_rdy     = !s3_v_q || out_rdy;
  assign s2_rdy     = !s2_v_q || s3_rdy;
  assign s1_rdy     = !s1_v_q || s2_rdy;
  assign in_ready_o = s1_rdy;

  logic s1_move, s2_move, s3_move;
  assign s1_move = s1_v_q && s2_rdy;
  assign s2_move = s2_v_q && s3_rdy;
  assign s3_move = s3_v_q && out_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_rdy)  s1_v_q  <= in_valid_i;
      if (s2_rdy)  s2_v_q  <= s1_v_q;
      if (s3_rdy)  s3_v_q  <= s2_v_q;
      if (out_rdy) out_v_q <= s3_v_q;
    end
  end

  // Input register.
  logic [SAMPLE_BITS-1:0] s1_sample_q;

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_rdy) begin
      s1_sample_q <= sample_i;
    end
  end

  // Block accumulator: running sum, fill count and the extreme trackers.
  // Equal words are kept as separate entries, so a repeated extreme is
  // dropped once per copy.
  logic [CNT_W-1:0]       fill_q, fill_d;
  logic [TOT_W-1:0]       total_q, total_d, total_sum;
  logic [SAMPLE_BITS-1:0] sm0_q, sm1_q, lg0_q, lg1_q;
  logic [SAMPLE_BITS-1:0] sm0_d, sm1_d, lg0_d, lg1_d;
  logic [SAMPLE_BITS-1:0] sm0_n, sm1_n, lg0_n, lg1_n;
  logic                   last;

  assign total_sum = total_q + TOT_W'(s1_sample_q);
  assign last      = (fill_q == LAST_COUNT);

  always_comb begin
    sm0_n = sm0_q;
    sm1_n = sm1_q;
    lg0_n = lg0_q;
    lg1_n = lg1_q;
    if (s1_sample_q < sm0_q) begin
      sm1_n = sm0_q;
      sm0_n = s1_sample_q;
    end else if (s1_sample_q < sm1_q) begin
      sm1_n = s1_sample_q;
    end
    if (s1_sample_q > lg0_q) begin
      lg1_n = lg0_q;
      lg0_n = s1_sample_q;
    end else if (s1_sample_q > lg1_q) begin
      lg1_n = s1_sample_q;
    end

    fill_d  = fill_q;
    total_d = total_q;
    sm0_d   = sm0_q;
    sm1_d   = sm1_q;
    lg0_d   = lg0_q;
    lg1_d   = lg1_q;
    if (s1_move) begin
      if (last) begin
        // The closing word starts a fresh block.
        fill_d  = '0;
        total_d = '0;
        sm0_d   = SMALLEST_RESET;
        sm1_d   = SMALLEST_RESET;
        lg0_d   = '0;
        lg1_d   = '0;
      end else begin
        fill_d  = fill_q + 1'b1;
        total_d = total_sum;
        sm0_d   = sm0_n;
        sm1_d   = sm1_n;
        lg0_d   = lg0_n;
        lg1_d   = lg1_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      total_q <= '0;
      sm0_q   <= SMALLEST_RESET;
      sm1_q   <= SMALLEST_RESET;
      lg0_q   <= '0;
      lg1_q   <= '0;
    end else begin
      fill_q  <= fill_d;
      total_q <= total_d;
      sm0_q   <= sm0_d;
      sm1_q   <= sm1_d;
      lg0_q   <= lg0_d;
      lg1_q   <= lg1_d;
    end
  end

  // Stage 2 holds the summary of a closed block (meaningful only with the
  // end mark set).
  logic                   s2_end_q;
  logic [TOT_W-1:0]       s2_total_q;
  logic [SAMPLE_BITS-1:0] s2_sm0_q, s2_sm1_q, s2_lg0_q, s2_lg1_q;

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      s2_end_q   <= last;
      s2_total_q <= total_sum;
      s2_sm0_q   <= sm0_n;
      s2_sm1_q   <= sm1_n;
      s2_lg0_q   <= lg0_n;
      s2_lg1_q   <= lg1_n;
    end
  end

  // Stage 3: numerator for the divider. In trimmed mode the extremes leave
  // the sum; the remaining words always cover them, so no underflow occurs.
  logic [TOT_W-1:0] drop;
  logic             s3_end_q, s3_trim_q;
  logic [TOT_W-1:0] s3_numer_q;

  assign drop = TOT_W'(s2_sm0_q) + TOT_W'(s2_lg0_q)
              + ((TRIM > 1) ? (TOT_W'(s2_sm1_q) + TOT_W'(s2_lg1_q)) : '0);

  always_ff @(posedge clk_i) begin
    if (s2_move) begin
      s3_end_q   <= s2_end_q;
      s3_trim_q  <= mode_q;
      s3_numer_q <= mode_q ? (s2_total_q - drop) : s2_total_q;
    end
  end

  // Output stage: the held value changes only on a block end.
  logic [SAMPLE_BITS-1:0] quot;
  logic [SAMPLE_BITS-1:0] held_q, held_d;
  logic [SAMPLE_BITS-1:0] filtered_q;
  logic                   over_q, end_q;

  tmf_divide #(
    .WINDOW (WINDOW),
    .TRIM   (TRIM)
  ) u_divide (
    .numer_i (s3_numer_q),
    .trim_i  (s3_trim_q),
    .quot_o  (quot)
  );

  assign held_d = (s3_move && s3_end_q) ? quot : held_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else begin
      held_q <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_move) begin
      filtered_q <= held_d;
      over_q     <= (held_d > thresh_q);
      end_q      <= s3_end_q;
    end
  end

  assign out_valid_o  = out_v_q;
  assign filtered_o   = filtered_q;
  assign over_limit_o = over_q;
  assign block_end_o  = end_q;

endmodule

[sv/tmf_checker.sv]
`include "assert_macros.svh"

// Port-level checks for the block filter.
module tmf_checker import tmf_pkg::*; #(
  parameter int WINDOW = DEFAULT_WINDOW
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [SAMPLE_BITS-1:0] filtered_o,
  input logic                   block_end_o
);

  localparam int CNT_W = $clog2(WINDOW);
  localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(WINDOW - 1);

  logic                   in_acc, out_acc;
  logic [SAMPLE_BITS-1:0] last_q;
  logic [CNT_W-1:0]       cnt_q;
  logic [2:0]             pending_q;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q    <= '0;
      cnt_q     <= '0;
      pending_q <= '0;
    end else begin
      if (out_acc) begin
        last_q <= filtered_o;
        cnt_q  <= (cnt_q == LAST_COUNT) ? '0 : cnt_q + 1'b1;
      end
      if (in_acc && !out_acc) begin
        pending_q <= pending_q + 1'b1;
      end else if (!in_acc && out_acc) begin
        pending_q <= pending_q - 1'b1;
      end
    end
  end

  // A stalled word keeps its value.
  `ASSERT_PROP(a_out_hold, clk_i, rst_ni, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(filtered_o) && $stable(block_end_o)))
  // The filtered value moves only on a block end.
  `ASSERT_IMPL(a_held_steady, clk_i, rst_ni, out_valid_o && !block_end_o, filtered_o == last_q)
  // Every WINDOW-th word closes a block, and no other word does.
  `ASSERT_IMPL(a_block_end, clk_i, rst_ni, out_valid_o, block_end_o == (cnt_q == LAST_COUNT))
  // No result without a word in flight, and no more in flight than stages.
  `ASSERT_IMPL(a_no_extra, clk_i, rst_ni, out_valid_o, pending_q != 3'd0)
  `ASSERT_PROP(a_depth, clk_i, rst_ni, pending_q <= 3'd4)

endmodule

bind block_trimmed_mean_filter tmf_checker #(
  .WINDOW (WINDOW)
) u_tmf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .filtered_o  (filtered_o),
  .block_end_o (block_end_o)
);

[test/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tmf_pkg::*;

  // Block geometry matches the defaults that the filter is built with.
  localparam int WINDOW = DEFAULT_WINDOW;
  localparam int TRIM   = DEFAULT_TRIM;

  localparam logic MODE_PLAIN   = 1'b0;
  localparam logic MODE_TRIMMED = 1'b1;

  localparam int RANDOM_WORDS   = 530;
  localparam int MAX_REPORTS    = 10;
  // Clock edges waited after the drain, in which a stray output word would show.
  localparam int DRAIN_CYCLES   = 12;
  // The longest sender gap and the longest receiver stall are far shorter than
  // this limit, so reaching it without any handshake means the filter is stuck.
  localparam int WATCHDOG_LIMIT = 1000;

  // One output word as the filter should present it.
  typedef struct {
    logic [SAMPLE_BITS-1:0] filtered;
    logic                   over_limit;
    logic                   block_end;
  } result_word_t;

  // Shapes of sample blocks. Flat and clustered blocks put duplicated values at
  // the extremes, spikes put lone outliers there.
  typedef enum {
    SHAPE_UNIFORM,
    SHAPE_TIES,
    SHAPE_SPIKES,
    SHAPE_NARROW,
    SHAPE_FULL_SCALE,
    SHAPE_ZERO
  } block_shape_e;

  // Tracks the filter state word by word and holds the output words that are
  // still owed, oldest first.
  class filter_scoreboard;
    logic                   mode;
    logic [SAMPLE_BITS-1:0] threshold;
    int unsigned            fill;
    logic [16:0]            block_sum;
    logic [SAMPLE_BITS-1:0] lowest[2];
    logic [SAMPLE_BITS-1:0] highest[2];
    logic [SAMPLE_BITS-1:0] held;
    result_word_t           owed_words[$];
    int                     errors;
    int                     word_count;

    function new();
      mode       = MODE_PLAIN;
      threshold  = THRESHOLD_RESET;
      held       = '0;
      errors     = 0;
      word_count = 0;
      restart_block();
    endfunction

    function void restart_block();
      fill       = 0;
      block_sum  = '0;
      lowest[0]  = SMALLEST_RESET;
      lowest[1]  = SMALLEST_RESET;
      highest[0] = '0;
      highest[1] = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_FILTER_MODE) begin
        mode = data[0];
      end else if (idx == CFG_LIMIT_THRESHOLD) begin
        threshold = data[SAMPLE_BITS-1:0];
      end
    endfunction

    // Truncated mean of the block, with the extremes taken out in trimmed mode.
    function logic [SAMPLE_BITS-1:0] block_mean();
      int unsigned total;
      total = block_sum;
      if (mode == MODE_PLAIN) begin
        return SAMPLE_BITS'(total / WINDOW);
      end
      for (int k = 0; k < TRIM && k < 2; k++) begin
        total = total - lowest[k] - highest[k];
      end
      return SAMPLE_BITS'(total / (WINDOW - 2 * TRIM));
    endfunction

    function void note_sample(logic [SAMPLE_BITS-1:0] s);
      result_word_t w;
      block_sum = block_sum + s;
      // Equal values take separate slots, so a repeated extreme drops twice.
      if (s < lowest[0]) begin
        lowest[1] = lowest[0];
        lowest[0] = s;
      end else if (s < lowest[1]) begin
        lowest[1] = s;
      end
      if (s > highest[0]) begin
        highest[1] = highest[0];
        highest[0] = s;
      end else if (s > highest[1]) begin
        highest[1] = s;
      end
      fill++;
      w.block_end = 1'b0;
      if (fill >= WINDOW) begin
        held = block_mean();
        restart_block();
        w.block_end = 1'b1;
      end
      w.filtered   = held;
      w.over_limit = held > threshold;
      owed_words.push_back(w);
    endfunction

    function void check_result(result_word_t got);
      result_word_t want;
      word_count++;
      if (owed_words.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("output word %0d arrived with none owed: filtered=%0d over=%0b end=%0b",
                   word_count, got.filtered, got.over_limit, got.block_end);
        end
        return;
      end
      want = owed_words.pop_front();
      if (got.filtered !== want.filtered || got.over_limit !== want.over_limit ||
          got.block_end !== want.block_end) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("output word %0d: expected filtered=%0d over=%0b end=%0b, got %0d %0b %0b",
                   word_count, want.filtered, want.over_limit, want.block_end,
                   got.filtered, got.over_limit, got.block_end);
        end
      end
    endfunction

    function int pending();
      return owed_words.size();
    endfunction
  endclass

  logic                   clk_i        = 1'b0;
  logic                   rst_ni       = 1'b0;
  logic                   in_valid_i   = 1'b0;
  logic                   in_ready_o;
  logic [SAMPLE_BITS-1:0] sample_i     = '0;
  logic                   out_valid_o;
  logic                   out_ready_i  = 1'b0;
  logic [SAMPLE_BITS-1:0] filtered_o;
  logic                   over_limit_o;
  logic                   block_end_o;
  logic                   cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index_i  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i   = '0;

  filter_scoreboard board = new();
  int               stuck_cycles = 0;

  // Shape of the block that the sender is filling right now.
  block_shape_e           shape;
  logic [SAMPLE_BITS-1:0] shape_lo;
  logic [SAMPLE_BITS-1:0] shape_hi;

  block_trimmed_mean_filter #(
    .WINDOW (WINDOW),
    .TRIM   (TRIM)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_i     (sample_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .filtered_o   (filtered_o),
    .over_limit_o (over_limit_o),
    .block_end_o  (block_end_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // Reset is asserted from time zero and released once.
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Both channels are observed at the clock edge, before any register moves.
  // The input side feeds the scoreboard, the output side is checked against it.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        board.note_sample(sample_i);
      end
      if (out_valid_o && out_ready_i) begin
        board.check_result(result_word_t'{filtered: filtered_o, over_limit: over_limit_o,
                                          block_end: block_end_o});
      end
    end
  end

  // The run is declared hung after too many cycles with no handshake at all.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // The receiver alternates ready stretches, some long, with stalls that are
  // mostly short and now and then long. A quarter of the time no stall
  // follows, which joins ready stretches together.
  initial begin
    int run_len;
    int stall_len;
    int pick;
    @(posedge clk_i);
    forever begin
      run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
      out_ready_i <= 1'b1;
      repeat (run_len) @(posedge clk_i);
      pick = $urandom_range(0, 11);
      if (pick < 3) begin
        stall_len = 0;
      end else if (pick < 11) begin
        stall_len = $urandom_range(1, 3);
      end else begin
        stall_len = $urandom_range(10, 40);
      end
      if (stall_len > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall_len) @(posedge clk_i);
      end
    end
  end

  // Sender gap before the next word. Burst phases send back to back.
  function automatic int pick_gap(bit burst);
    int pick;
    if (burst) begin
      return 0;
    end
    pick = $urandom_range(0, 19);
    if (pick < 10) begin
      return 0;
    end else if (pick < 18) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Picks the shape of the next block and the value range that it draws from.
  function automatic void choose_block_shape();
    int pick;
    pick     = $urandom_range(0, 9);
    shape_lo = SAMPLE_BITS'($urandom_range(0, 4095));
    shape_hi = SAMPLE_BITS'($urandom_range(shape_lo, 4095));
    case (pick)
      0, 1, 2: shape = SHAPE_UNIFORM;
      3, 4:    shape = SHAPE_TIES;
      5, 6:    shape = SHAPE_SPIKES;
      7: begin
        shape    = SHAPE_NARROW;
        shape_hi = (shape_lo > 4095 - 40) ? 12'hfff : shape_lo + 12'd40;
      end
      8:       shape = SHAPE_FULL_SCALE;
      default: shape = SHAPE_ZERO;
    endcase
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] next_sample();
    case (shape)
      SHAPE_TIES: begin
        // Mostly the two ends of the range, so extremes come in copies.
        case ($urandom_range(0, 2))
          0:       return shape_lo;
          1:       return shape_hi;
          default: return SAMPLE_BITS'($urandom_range(shape_lo, shape_hi));
        endcase
      end
      SHAPE_SPIKES: begin
        if ($urandom_range(0, 7) == 0) begin
          return $urandom_range(0, 1) ? '1 : '0;
        end
        return shape_lo;
      end
      SHAPE_NARROW:     return SAMPLE_BITS'($urandom_range(shape_lo, shape_hi));
      SHAPE_FULL_SCALE: return '1;
      SHAPE_ZERO:       return '0;
      default:          return SAMPLE_BITS'($urandom_range(0, 4095));
    endcase
  endfunction

  // The first phases walk through the threshold extremes and the boundary
  // around the held value; later ones mix those with random thresholds.
  function automatic logic [SAMPLE_BITS-1:0] pick_threshold(int phase);
    int pick;
    pick = (phase < 4) ? phase : $urandom_range(0, 5);
    case (pick)
      0:       return '0;
      1:       return '1;
      2:       return board.held;
      3:       return board.held - 1'b1;
      4:       return board.held + 1'b1;
      default: return SAMPLE_BITS'($urandom_range(0, 4095));
    endcase
  endfunction

  // Writes both registers on back-to-back cycles, keeping the write enable high
  // across the pair. The mode word carries random upper bits, which the filter
  // must ignore.
  task automatic write_config(logic mode_bit, logic [SAMPLE_BITS-1:0] threshold);
    logic [CFG_DATA_W-1:0] mode_word;
    mode_word    = CFG_DATA_W'($urandom);
    mode_word[0] = mode_bit;
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_FILTER_MODE;
    cfg_data_i  <= mode_word;
    @(posedge clk_i);
    board.write_reg(CFG_FILTER_MODE, mode_word);
    cfg_index_i <= CFG_LIMIT_THRESHOLD;
    cfg_data_i  <= CFG_DATA_W'(threshold);
    @(posedge clk_i);
    board.write_reg(CFG_LIMIT_THRESHOLD, CFG_DATA_W'(threshold));
    cfg_we_i <= 1'b0;
  endtask

  // Offers one word after the given gap and returns at the edge that takes it.
  // Valid stays high on return, so a zero gap keeps the channel busy.
  task automatic push_sample(logic [SAMPLE_BITS-1:0] s, int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Every word gives one output word, so an empty scoreboard means the
  // pipeline is empty too. The first edge lets the monitor note a word that
  // was taken at the edge where the caller stands.
  task automatic wait_idle();
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [SAMPLE_BITS-1:0] directed[$];
    int                     sent;
    int                     phase;
    int                     words;
    int                     block_pos;
    bit                     burst;
    logic                   mode_bit;

    wait (rst_ni);
    @(posedge clk_i);
    write_config(MODE_PLAIN, 12'h800);

    // Field extremes, every single bit set, and alternating and repeated
    // patterns. These twenty words leave the first block part full, so the first
    // random phase closes it under whatever mode that phase selects.
    directed = '{12'h000, 12'hfff};
    for (int i = 0; i < SAMPLE_BITS; i++) begin
      directed.push_back(SAMPLE_BITS'(1) << i);
    end
    directed.push_back(12'haaa);
    directed.push_back(12'h555);
    directed.push_back(12'hfff);
    directed.push_back(12'hfff);
    directed.push_back(12'h000);
    directed.push_back(12'h000);
    foreach (directed[i]) begin
      push_sample(directed[i], pick_gap(1'b0));
    end
    in_valid_i <= 1'b0;
    block_pos = directed.size();

    // Random phases. Phase lengths are not tied to the block size, so mode
    // changes land in the middle of blocks as well as at their edges.
    choose_block_shape();
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_WORDS) begin
      wait_idle();
      mode_bit = (phase < 4) ? ((phase % 2 == 0) ? MODE_TRIMMED : MODE_PLAIN)
                             : 1'($urandom_range(0, 1));
      write_config(mode_bit, pick_threshold(phase));
      words = $urandom_range(15, 80);
      if (words > RANDOM_WORDS - sent) begin
        words = RANDOM_WORDS - sent;
      end
      burst = ($urandom_range(0, 3) == 0);
      repeat (words) begin
        if (block_pos == 0) begin
          choose_block_shape();
        end
        push_sample(next_sample(), pick_gap(burst));
        block_pos = (block_pos + 1) % WINDOW;
        sent++;
      end
      in_valid_i <= 1'b0;
      phase++;
    end

    // Let the last words drain, then keep watching the output port, so that any
    // stray output word would be caught before the run ends.
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
